// ===== hdl/thl_pkg.sv =====
// Shared types, widths and segment constants for the thermistor linearizer.
// Used by thl_div and thermistor_temperature_linearizer. No dependencies.
package thl_pkg;

    localparam int SAMPLE_W = 10;
    localparam int TEMP_W   = 7;
    localparam int DIV_N_W  = 25;
    localparam int DIV_D_W  = 12;
    localparam int DIV_C_W  = 5;
    localparam int MV_W     = 12;
    localparam int RES_W    = 15;
    localparam int SEG_W    = 4;

    localparam logic [DIV_C_W-1:0] DIV_LAST  = DIV_C_W'(DIV_N_W - 1);
    localparam logic [SEG_W-1:0]   SEG_LAST  = 4'd9;
    localparam logic [MV_W-1:0]    MV_FULL   = 12'd3300;
    localparam logic [11:0]        MV_SCALE  = 12'd3300;
    localparam logic [13:0]        R_SCALE   = 14'd10000;
    localparam logic [DIV_N_W-1:0] R_LIMIT   = 25'd29371;

    typedef logic [DIV_N_W-1:0] div_num_t;
    typedef logic [DIV_D_W-1:0] div_den_t;

    typedef struct packed {
        logic     start;
        div_num_t dividend;
        div_den_t divisor;
    } div_req_t;

    typedef struct packed {
        logic     done;
        div_num_t quotient;
    } div_rsp_t;

    function automatic logic [RES_W-1:0] seg_low(input logic [SEG_W-1:0] idx);
        logic [RES_W-1:0] v;
        v = '0;
        unique case (idx)
            4'd0: v = 15'd18680;
            4'd1: v = 15'd12240;
            4'd2: v = 15'd8221;
            4'd3: v = 15'd5648;
            4'd4: v = 15'd3958;
            4'd5: v = 15'd2832;
            4'd6: v = 15'd2047;
            4'd7: v = 15'd1506;
            4'd8: v = 15'd1124;
            4'd9: v = 15'd850;
            default: v = '1;
        endcase
        return v;
    endfunction

    function automatic logic [RES_W-1:0] seg_top(input logic [SEG_W-1:0] idx);
        logic [RES_W-1:0] v;
        v = '0;
        unique case (idx)
            4'd0: v = 15'd29370;
            4'd1: v = 15'd18680;
            4'd2: v = 15'd12240;
            4'd3: v = 15'd8221;
            4'd4: v = 15'd5648;
            4'd5: v = 15'd3957;
            4'd6: v = 15'd2831;
            4'd7: v = 15'd2046;
            4'd8: v = 15'd1505;
            4'd9: v = 15'd1123;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic div_den_t seg_slope(input logic [SEG_W-1:0] idx);
        div_den_t v;
        v = '0;
        unique case (idx)
            4'd0: v = 12'd1069;
            4'd1: v = 12'd644;
            4'd2: v = 12'd402;
            4'd3: v = 12'd250;
            4'd4: v = 12'd169;
            4'd5: v = 12'd113;
            4'd6: v = 12'd76;
            4'd7: v = 12'd54;
            4'd8: v = 12'd38;
            4'd9: v = 12'd28;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [TEMP_W-1:0] seg_off(input logic [SEG_W-1:0] idx);
        logic [TEMP_W-1:0] v;
        v = '0;
        unique case (idx)
            4'd0: v = 7'd0;
            4'd1: v = 7'd7;
            4'd2: v = 7'd17;
            4'd3: v = 7'd28;
            4'd4: v = 7'd40;
            4'd5: v = 7'd50;
            4'd6: v = 7'd60;
            4'd7: v = 7'd70;
            4'd8: v = 7'd80;
            4'd9: v = 7'd90;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/thl_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on thl_pkg for widths and the request/response structs.
module thl_div
    import thl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_C_W-1:0] cnt_reg, cnt_next;
    div_den_t           rem_reg, rem_next;
    div_den_t           den_reg, den_next;
    div_num_t           quo_reg, quo_next;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_N_W-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_D_W'(trial - {1'b0, den_reg}) : trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/thermistor_temperature_linearizer.sv =====
// Top level of the thermistor linearizer: averaging, scaling and segment lookup.
// Depends on thl_pkg and thl_div.
//
// Each sample is a one-cycle transfer. The sample that completes a group of
// SAMPLES starts the conversion and holds sample_stall high until the result
// is loaded into the output register. The average and the resistance each take
// a request to the shared bit-serial divider. The segment scan tries one
// segment per cycle. A resistance inside a segment needs a third division
// before the result is loaded. A result waiting in the output register does
// not hold off samples that only accumulate.
module thermistor_temperature_linearizer
    import thl_pkg::*;
#(
    parameter int SAMPLES = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [TEMP_W-1:0]   temperature,
    output logic                out_of_range
);

    localparam int SUM_W = $clog2(SAMPLES * 1023 + 1);
    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_AVG      = 4'd1;
    localparam logic [3:0] S_AVG_WAIT = 4'd2;
    localparam logic [3:0] S_MV       = 4'd3;
    localparam logic [3:0] S_RES      = 4'd4;
    localparam logic [3:0] S_RES_WAIT = 4'd5;
    localparam logic [3:0] S_SEG      = 4'd6;
    localparam logic [3:0] S_TMP_WAIT = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [MV_W-1:0]     mv_reg, mv_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic                high_reg, high_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic [TEMP_W-1:0]   pend_temp_reg, pend_temp_next;
    logic                pend_oor_reg, pend_oor_next;
    logic                rvalid_reg, rvalid_next;
    logic [TEMP_W-1:0]   temp_reg, temp_next;
    logic                oor_reg, oor_next;

    logic [SUM_W-1:0]    sum_total;
    logic [21:0]         mv_prod;
    logic [25:0]         num_prod;
    logic [RES_W-1:0]    top;
    logic [RES_W-1:0]    diff;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    thl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sum_total = sum_reg + SUM_W'(sample);
    assign mv_prod   = avg_reg * MV_SCALE;
    assign num_prod  = mv_reg * R_SCALE;
    assign top       = seg_top(seg_reg);
    assign diff      = (top > res_reg) ? (top - res_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        avg_next       = avg_reg;
        mv_next        = mv_reg;
        res_next       = res_reg;
        high_next      = high_reg;
        seg_next       = seg_reg;
        pend_temp_next = pend_temp_reg;
        pend_oor_next  = pend_oor_reg;
        rvalid_next    = rvalid_reg && result_stall;
        temp_next      = temp_reg;
        oor_next       = oor_reg;
        div_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    sum_next = sum_total;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = S_AVG;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_AVG:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(sum_reg);
                div_req.divisor  = DIV_D_W'(SAMPLES);
                sum_next         = '0;
                cnt_next         = '0;
                state_next       = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[SAMPLE_W-1:0];
                    state_next = S_MV;
                end
            end
            S_MV:
            begin
                mv_next    = mv_prod[21:10];
                state_next = S_RES;
            end
            S_RES:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_prod[DIV_N_W-1:0];
                div_req.divisor  = MV_FULL - mv_reg;
                state_next       = S_RES_WAIT;
            end
            S_RES_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_next   = div_rsp.quotient[RES_W-1:0];
                    high_next  = div_rsp.quotient >= R_LIMIT;
                    seg_next   = '0;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                priority if (high_reg)
                begin
                    pend_temp_next = '0;
                    pend_oor_next  = 1'b1;
                    state_next     = S_DONE;
                end
                else if (res_reg > seg_low(seg_reg))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_W'(diff);
                    div_req.divisor  = seg_slope(seg_reg);
                    state_next       = S_TMP_WAIT;
                end
                else if (seg_reg == SEG_LAST)
                begin
                    pend_temp_next = '0;
                    pend_oor_next  = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    seg_next = seg_reg + 1'b1;
                end
            end
            S_TMP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    pend_temp_next = div_rsp.quotient[TEMP_W-1:0] + seg_off(seg_reg);
                    pend_oor_next  = 1'b0;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rvalid_reg || !result_stall)
                begin
                    rvalid_next = 1'b1;
                    temp_next   = pend_temp_reg;
                    oor_next    = pend_oor_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg       <= avg_next;
        mv_reg        <= mv_next;
        res_reg       <= res_next;
        high_reg      <= high_next;
        seg_reg       <= seg_next;
        pend_temp_reg <= pend_temp_next;
        pend_oor_reg  <= pend_oor_next;
        temp_reg      <= temp_next;
        oor_reg       <= oor_next;
    end

    assign sample_stall = state_reg != S_IDLE;
    assign result_valid = rvalid_reg;
    assign temperature  = temp_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== tb/thermistor_temperature_linearizer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the thermistor linearizer: watches both transfer channels, forms the
// expected reading of every averaged group and compares it with the block's output.
// Depends on thl_pkg for field widths.
module thermistor_temperature_linearizer_checker
    import thl_pkg::*;
#(
    parameter int SAMPLES = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    input  logic                sample_stall,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                result_valid,
    input  logic                result_stall,
    input  logic [TEMP_W-1:0]   temperature,
    input  logic                out_of_range,
    output int unsigned         mismatches,
    output int unsigned         readings_outstanding
);

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic              out_of_range;
    } reading_t;

    typedef struct packed {
        logic [14:0] floor_ohms;
        logic [14:0] top_ohms;
        logic [11:0] slope;
        logic [6:0]  base;
    } band_t;

    reading_t    readings_due [$];
    reading_t    due;
    logic [14:0] sample_total;
    logic [4:0]  samples_taken;

    function automatic band_t band_of(input int idx);
        band_t b;
        case (idx)
            0:       b = {15'd18680, 15'd29370, 12'd1069, 7'd0};
            1:       b = {15'd12240, 15'd18680, 12'd644,  7'd7};
            2:       b = {15'd8221,  15'd12240, 12'd402,  7'd17};
            3:       b = {15'd5648,  15'd8221,  12'd250,  7'd28};
            4:       b = {15'd3958,  15'd5648,  12'd169,  7'd40};
            5:       b = {15'd2832,  15'd3957,  12'd113,  7'd50};
            6:       b = {15'd2047,  15'd2831,  12'd76,   7'd60};
            7:       b = {15'd1506,  15'd2046,  12'd54,   7'd70};
            8:       b = {15'd1124,  15'd1505,  12'd38,   7'd80};
            default: b = {15'd850,   15'd1123,  12'd28,   7'd90};
        endcase
        return b;
    endfunction

    function automatic reading_t temperature_from_average(input logic [SAMPLE_W-1:0] average);
        int unsigned millivolts;
        int unsigned ohms;
        int unsigned span;
        band_t       b;
        reading_t    rd;
        logic        found;
        millivolts = (32'(average) * 32'd3300) / 32'd1024;
        if (millivolts > 32'd3296)
            millivolts = 32'd3296;
        ohms = (millivolts * 32'd10000) / (32'd3300 - millivolts);
        rd.temperature  = '0;
        rd.out_of_range = 1'b1;
        found = 1'b0;
        if (ohms < 32'd29371)
        begin
            for (int i = 0; i < 10; i++)
            begin
                b = band_of(i);
                if (!found && ohms > 32'(b.floor_ohms))
                begin
                    span = (32'(b.top_ohms) > ohms) ? 32'(b.top_ohms) - ohms : 32'd0;
                    rd.temperature  = TEMP_W'(span / 32'(b.slope) + 32'(b.base));
                    rd.out_of_range = 1'b0;
                    found = 1'b1;
                end
            end
        end
        return rd;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_total  = '0;
            samples_taken = '0;
            readings_due.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (readings_due.size() == 0)
                    report_mismatch($sformatf("result with none due: temperature %0d out_of_range %0b",
                                              temperature, out_of_range));
                else
                begin
                    due = readings_due.pop_front();
                    if (temperature !== due.temperature || out_of_range !== due.out_of_range)
                        report_mismatch($sformatf(
                            "temperature %0d (due %0d), out_of_range %0b (due %0b)",
                            temperature, due.temperature, out_of_range, due.out_of_range));
                end
            end
            if (sample_valid && !sample_stall)
            begin
                sample_total  = sample_total + 15'(sample);
                samples_taken = samples_taken + 5'd1;
                if (samples_taken == SAMPLES)
                begin
                    readings_due.push_back(
                        temperature_from_average(SAMPLE_W'(sample_total / SAMPLES)));
                    sample_total  = '0;
                    samples_taken = '0;
                end
            end
        end
        readings_outstanding = readings_due.size();
    end

endmodule

// ===== tb/thermistor_temperature_linearizer_tb.sv =====
`timescale 1ns / 100ps
// Top of the thermistor linearizer testbench: clock, reset, sample and stall stimulus,
// watchdog and verdict. Depends on thl_pkg, the block and the checker module.
module thermistor_temperature_linearizer_tb;
    import thl_pkg::*;

    localparam int GROUP         = 5;
    localparam int RANDOM_GROUPS = 215;
    localparam int CALM_GROUPS   = 30;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 120;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample       = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [TEMP_W-1:0]   temperature;
    logic                out_of_range;

    int unsigned mismatches;
    int unsigned readings_outstanding;
    int unsigned quiet_cycles = 0;
    bit          idling       = 1'b1;
    int          boundary_averages [$];

    thermistor_temperature_linearizer #(.SAMPLES(GROUP)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .temperature  (temperature),
        .out_of_range (out_of_range)
    );

    thermistor_temperature_linearizer_checker #(.SAMPLES(GROUP)) reading_check (
        .clk                  (clk),
        .rst_n                (rst_n),
        .sample_valid         (sample_valid),
        .sample_stall         (sample_stall),
        .sample               (sample),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .temperature          (temperature),
        .out_of_range         (out_of_range),
        .mismatches           (mismatches),
        .readings_outstanding (readings_outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned ohms_at(input int unsigned average);
        int unsigned millivolts;
        millivolts = average * 3300 / 1024;
        return millivolts * 10000 / (3300 - millivolts);
    endfunction

    function automatic int bucket_of(input int unsigned ohms);
        return (ohms >= 851) + (ohms >= 1124) + (ohms >= 1125) + (ohms >= 1506)
             + (ohms >= 1507) + (ohms >= 2047) + (ohms >= 2048) + (ohms >= 2832)
             + (ohms >= 2833) + (ohms >= 3958) + (ohms >= 3959) + (ohms >= 5649)
             + (ohms >= 8222) + (ohms >= 12241) + (ohms >= 18681) + (ohms >= 29371);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic send_group_around(input int target);
        int reach;
        int jitter;
        int extra;
        reach  = (target < 1023 - target) ? target : 1023 - target;
        jitter = $urandom_range(0, reach);
        send_sample(SAMPLE_W'(target + jitter));
        send_sample(SAMPLE_W'(target - jitter));
        jitter = $urandom_range(0, reach);
        send_sample(SAMPLE_W'(target - jitter));
        send_sample(SAMPLE_W'(target + jitter));
        extra = $urandom_range(0, GROUP - 1);
        if (target + extra > 1023)
            extra = 0;
        send_sample(SAMPLE_W'(target + extra));
    endtask

    // random result stall bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("thermistor_temperature_linearizer_tb failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int a = 1; a < 1024; a++)
        begin
            if (bucket_of(ohms_at(a)) != bucket_of(ohms_at(a - 1)))
            begin
                boundary_averages.push_back(a - 1);
                boundary_averages.push_back(a);
            end
        end

        // cold and hot ends, truncated average, bit patterns
        repeat (GROUP) send_sample('0);
        repeat (GROUP) send_sample('1);
        repeat (GROUP - 1) send_sample('1);
        send_sample(10'd1019);
        send_sample(10'h2AA);
        send_sample(10'h155);
        send_sample(10'h2AA);
        send_sample(10'h155);
        send_sample(10'h200);
        send_sample(10'h001);
        send_sample(10'h002);
        send_sample(10'h004);
        send_sample(10'h008);
        send_sample(10'h010);

        for (int g = 0; g < RANDOM_GROUPS; g++)
        begin
            if (g == RANDOM_GROUPS - CALM_GROUPS)
                idling = 1'b0;
            case ($urandom_range(0, 9))
                0, 1:
                    repeat (GROUP) send_sample(SAMPLE_W'($urandom_range(0, 1023)));
                2, 3:
                    send_group_around($urandom_range(0, 1023));
                default:
                    send_group_around(
                        boundary_averages[$urandom_range(0, boundary_averages.size() - 1)]);
            endcase
        end

        sample_valid <= 1'b0;
        @(posedge clk);
        while (readings_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && readings_outstanding == 0)
            $display("thermistor_temperature_linearizer_tb passed");
        else
            $display("thermistor_temperature_linearizer_tb failed");
        $finish;
    end

endmodule
